[rtl/assert_macros.svh]
// assertion macros shared by the median filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define GRMF_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("grmf assertion failed");

// same-cycle implication
`define GRMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grmf assertion failed");

// next-cycle implication
`define GRMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grmf assertion failed");

`else

`define GRMF_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define GRMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GRMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/grmf_pkg.sv]
// types and constants of the gated running median filter
`timescale 1ns / 1ps
package grmf_pkg;

  localparam int DIST_W        = 16;
  localparam int STATUS_W      = 8;
  localparam int WINDOW_DEF    = 5;

  localparam logic [DIST_W-1:0]   RANGE_LIMIT_RESET = 16'd8000;
  localparam logic [STATUS_W-1:0] NEW_SAMPLE_MASK   = 8'h07;

  typedef struct packed {
    logic [STATUS_W-1:0] interrupt_status;
    logic [DIST_W-1:0]   range_sample;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] median_distance;
    logic              distance_valid;
  } out_item_t;

  // handed left to right along the cell row
  typedef struct packed {
    logic passed;   // the oldest entry sits at or left of this cell
    logic rem_lt;   // remaining entry at this slot is <= new sample
  } cell_link_t;

endpackage

[rtl/grmf_cell.sv]
// one cell of the sorted sample row: value plus age tag
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grmf_cell #(
  parameter int WINDOW = grmf_pkg::WINDOW_DEF,
  parameter int INDEX  = 0,
  localparam int AGE_W = $clog2(WINDOW)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ins,
  input  logic [grmf_pkg::DIST_W-1:0] x,
  input  logic [grmf_pkg::DIST_W-1:0] left_val,
  input  logic [AGE_W-1:0]          left_age,
  input  logic [grmf_pkg::DIST_W-1:0] right_val,
  input  logic [AGE_W-1:0]          right_age,
  input  logic                      right_lt,
  input  grmf_pkg::cell_link_t      link_in,
  output grmf_pkg::cell_link_t      link_out,
  output logic                      lt_o,
  output logic [grmf_pkg::DIST_W-1:0] val_o,
  output logic [AGE_W-1:0]          age_o
);

  logic [grmf_pkg::DIST_W-1:0] val_r, val_nxt;
  logic [AGE_W-1:0]            age_r, age_nxt;
  logic                        oldest, before_r, left_before, at_k;

  assign lt_o        = (val_r <= x);
  assign oldest      = (age_r == AGE_W'(WINDOW - 1));
  assign before_r    = !(link_in.passed | oldest);
  assign left_before = !link_in.passed;

  assign link_out.passed = link_in.passed | oldest;
  assign link_out.rem_lt = before_r ? lt_o : right_lt;
  assign at_k            = !link_out.rem_lt && link_in.rem_lt;

  // slot below insert point keeps or pulls from right, the insert slot takes x, above it pulls from left or keeps
  always_comb begin
    if (link_out.rem_lt) begin
      val_nxt = before_r ? val_r : right_val;
      age_nxt = (before_r ? age_r : right_age) + AGE_W'(1);
    end else if (at_k) begin
      val_nxt = x;
      age_nxt = '0;
    end else begin
      val_nxt = left_before ? left_val : val_r;
      age_nxt = (left_before ? left_age : age_r) + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= AGE_W'(INDEX);
    end else if (ins) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val_o = val_r;
  assign age_o = age_r;

endmodule

[rtl/grmf_chain.sv]
// row of sorted cells with the median tap in the middle
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grmf_chain #(
  parameter int WINDOW = grmf_pkg::WINDOW_DEF,
  localparam int AGE_W = $clog2(WINDOW)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ins,
  input  logic [grmf_pkg::DIST_W-1:0] x,
  output logic [grmf_pkg::DIST_W-1:0] median
);

  logic [grmf_pkg::DIST_W-1:0] val_w  [WINDOW];
  logic [AGE_W-1:0]            age_w  [WINDOW];
  logic                        lt_w   [WINDOW];
  grmf_pkg::cell_link_t        link_w [WINDOW];
  logic [WINDOW-1:0]           oldest_v;
  logic [WINDOW-2:0]           order_ok;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    grmf_pkg::cell_link_t        lin;
    logic [grmf_pkg::DIST_W-1:0] lval, rval;
    logic [AGE_W-1:0]            lage, rage;
    logic                        rlt;

    if (i == 0) begin : g_left_edge
      assign lin  = '{passed: 1'b0, rem_lt: 1'b1};
      assign lval = '0;
      assign lage = '0;
    end else begin : g_left
      assign lin  = link_w[i-1];
      assign lval = val_w[i-1];
      assign lage = age_w[i-1];
    end

    if (i == WINDOW - 1) begin : g_right_edge
      assign rval = '0;
      assign rage = '0;
      assign rlt  = 1'b0;
    end else begin : g_right
      assign rval = val_w[i+1];
      assign rage = age_w[i+1];
      assign rlt  = lt_w[i+1];
    end

    grmf_cell #(.WINDOW(WINDOW), .INDEX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ins       (ins),
      .x         (x),
      .left_val  (lval),
      .left_age  (lage),
      .right_val (rval),
      .right_age (rage),
      .right_lt  (rlt),
      .link_in   (lin),
      .link_out  (link_w[i]),
      .lt_o      (lt_w[i]),
      .val_o     (val_w[i]),
      .age_o     (age_w[i])
    );

    assign oldest_v[i] = (age_w[i] == AGE_W'(WINDOW - 1));
  end

  for (genvar i = 0; i < WINDOW - 1; i++) begin : g_order
    assign order_ok[i] = (val_w[i] <= val_w[i+1]);
  end

  assign median = val_w[WINDOW/2];

  // exactly one entry is due for eviction, and the row stays sorted
  `GRMF_ASSERT_ALWAYS(a_one_oldest, clk, rst_n, $onehot(oldest_v))
  `GRMF_ASSERT_ALWAYS(a_row_sorted, clk, rst_n, &order_ok)

endmodule

[rtl/gated_running_median_filter_core.sv]
// top level of the gated running median filter
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel | direction | ports                          | moves
//  --------+-----------+--------------------------------+---------------------------
//  in      | input     | in_valid, in_ready, in_data    | status + range request
//  out     | output    | out_valid, out_ready, out_data | held median + valid flag
//  cfg     | input     | cfg_we, cfg_wdata              | range limit write
//
//  one request per cycle sustained while out_ready stays high; each accepted request
//  goes through the cell row update, then the median tap into the output register
//  the row of WINDOW cells sorts in place: each insert evicts the oldest entry and
//  drops the new range into its sorted slot, so the median is a fixed tap
//  synchronous active-low reset: cells hold zeros, limit goes to 8000, no result pending
//  out_ready low backs up through the stage register into in_ready; nothing is dropped
//
module gated_running_median_filter_core #(
  parameter int WINDOW = grmf_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  grmf_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output grmf_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [grmf_pkg::DIST_W-1:0] cfg_wdata
);

  // configuration
  logic [grmf_pkg::DIST_W-1:0] limit_r;

  // held state
  logic [grmf_pkg::DIST_W-1:0] held_dist_r, held_dist_nxt;
  logic                        held_valid_r, held_valid_nxt;

  // stage register between the cell row and the output register
  logic s1_valid_r, s1_valid_nxt;
  logic s1_upd_r;
  logic s1_hv_r;

  // output register
  logic                out_valid_r, out_valid_nxt;
  grmf_pkg::out_item_t out_data_r;

  logic                        in_acc, out_adv;
  logic                        flagged, in_range, ins;
  logic [grmf_pkg::DIST_W-1:0] median;

  assign out_adv  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_adv;
  assign in_acc   = in_valid && in_ready;

  // gate: any of the low status bits marks a fresh sample
  assign flagged  = |(in_data.interrupt_status & grmf_pkg::NEW_SAMPLE_MASK);
  assign in_range = (in_data.range_sample < limit_r);
  assign ins      = in_acc && flagged && in_range;

  assign held_valid_nxt = flagged ? in_range : held_valid_r;

  grmf_chain #(.WINDOW(WINDOW)) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ins    (ins),
    .x      (in_data.range_sample),
    .median (median)
  );

  // the row already holds this request's update when the stage register moves on
  assign held_dist_nxt = s1_upd_r ? median : held_dist_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= grmf_pkg::RANGE_LIMIT_RESET;
      held_dist_r  <= '0;
      held_valid_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (in_acc) begin
        held_valid_r <= held_valid_nxt;
      end
      if (out_adv) begin
        held_dist_r <= held_dist_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_upd_r <= ins;
      s1_hv_r  <= held_valid_nxt;
    end
    if (out_adv) begin
      out_data_r.median_distance <= held_dist_nxt;
      out_data_r.distance_valid  <= s1_hv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a pending stage that cannot drain must block new requests
  `GRMF_ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, s1_valid_r && !out_adv, !in_ready)
  // the valid flag only moves when a request is taken
  `GRMF_ASSERT_NEXT(a_flag_on_accept, clk, rst_n, !in_acc, $stable(held_valid_r))
  // the held median only moves when a result is loaded
  `GRMF_ASSERT_NEXT(a_dist_on_load, clk, rst_n, !out_adv, $stable(held_dist_r))

endmodule
